// ----- hdl/amed_pkg.sv -----
package amed_pkg;

	// Block constants
	localparam int FIR_TAPS_DEF = 5;
	localparam int REG_TAPS     = 5;
	localparam int ACC_W        = 37;
	localparam int PROD_W       = 51;
	localparam int MUL_A_W      = 18;
	localparam int MUL_B_W      = 33;

	localparam logic [15:0]        ALPHA_RESET = 16'd64225;
	localparam logic signed [15:0] TAP_RESET   = 16'sd6554;

	// Configuration register indexes
	localparam logic [2:0] REG_DC_ALPHA  = 3'd0;
	localparam logic [2:0] REG_TAP_ZERO  = 3'd1;
	localparam logic [2:0] REG_TAP_ONE   = 3'd2;
	localparam logic [2:0] REG_TAP_TWO   = 3'd3;
	localparam logic [2:0] REG_TAP_THREE = 3'd4;
	localparam logic [2:0] REG_TAP_FOUR  = 3'd5;

	// Program steps
	typedef logic [3:0] step_t;
	localparam step_t STEP_WAIT  = 4'd0;
	localparam step_t STEP_SQI   = 4'd1;
	localparam step_t STEP_SQQ   = 4'd2;
	localparam step_t STEP_ROOT0 = 4'd3;
	localparam step_t STEP_ROOT  = 4'd4;
	localparam step_t STEP_BLEND = 4'd5;
	localparam step_t STEP_DIFF  = 4'd6;
	localparam step_t STEP_MAC   = 4'd7;
	localparam step_t STEP_SUM   = 4'd8;
	localparam step_t STEP_OUT   = 4'd9;

	// Multiplier operand selection
	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_II,
		MUL_QQ,
		MUL_AW,
		MUL_TAP,
		MUL_CLR
	} mul_sel_t;

	// Jump conditions
	typedef enum logic [2:0] {
		JMP_NONE,
		JMP_IN_IDLE,
		JMP_ROOT_MORE,
		JMP_TAP_MORE,
		JMP_OUT_BUSY
	} jmp_t;

	// One control word
	typedef struct packed {
		mul_sel_t mul;
		logic     load_in;
		logic     pw_load;
		logic     root_init;
		logic     root_step;
		logic     blend;
		logic     diff;
		logic     mac;
		logic     sum;
		logic     out_ld;
		logic     last;
		jmp_t     jmp;
		step_t    target;
	} uop_t;

	// Control store
	function automatic uop_t uop_rom(input step_t s);
		uop_t u;
		u = '0;
		u.mul = MUL_NONE;
		u.jmp = JMP_NONE;
		u.target = STEP_WAIT;
		case (s)
			STEP_WAIT: begin
				u.load_in = 1'b1;
				u.jmp = JMP_IN_IDLE;
				u.target = STEP_WAIT;
			end
			STEP_SQI: begin
				u.mul = MUL_II;
			end
			STEP_SQQ: begin
				u.mul = MUL_QQ;
				u.pw_load = 1'b1;
			end
			STEP_ROOT0: begin
				u.mul = MUL_AW;
				u.root_init = 1'b1;
			end
			STEP_ROOT: begin
				u.root_step = 1'b1;
				u.jmp = JMP_ROOT_MORE;
				u.target = STEP_ROOT;
			end
			STEP_BLEND: begin
				u.blend = 1'b1;
			end
			STEP_DIFF: begin
				u.mul = MUL_CLR;
				u.diff = 1'b1;
			end
			STEP_MAC: begin
				u.mul = MUL_TAP;
				u.mac = 1'b1;
				u.jmp = JMP_TAP_MORE;
				u.target = STEP_MAC;
			end
			STEP_SUM: begin
				u.sum = 1'b1;
			end
			STEP_OUT: begin
				u.out_ld = 1'b1;
				u.last = 1'b1;
				u.jmp = JMP_OUT_BUSY;
				u.target = STEP_OUT;
			end
			default: begin
				u.last = 1'b1;
			end
		endcase
		return u;
	endfunction

endpackage

// ----- hdl/am_envelope_detector.sv -----
// A finished word is held at the output step while the previous output word still waits.
// A new input word is taken only once the previous one has passed the 16-step square root
// and the tap loop, both run on one shared multiplier/adder datapath by the sequencer.
// Reset (arst_n low): registers go to their default values, DC accumulator and delay
// line clear, the sequencer returns to its start step and no output word is pending.
module am_envelope_detector #(
	parameter int FIR_TAPS = amed_pkg::FIR_TAPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] sample_i, [31:16] sample_q
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [17:0] audio_sample, [23:18] zero
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import amed_pkg::*;

	localparam int USED = (FIR_TAPS < REG_TAPS) ? FIR_TAPS : REG_TAPS;
	localparam int KW   = (USED > 1) ? $clog2(USED) : 1;

	// Configuration registers
	logic [15:0]        alpha_q;
	logic signed [15:0] tap_q [REG_TAPS];

	// Sequencer
	step_t step_q;
	uop_t  uop;
	logic  jump;
	logic  in_fire;
	logic  out_busy;

	// Datapath registers
	logic signed [15:0]       si_q, sq_q;
	logic [31:0]              pw_q;
	logic [31:0]              rem_q, root_q, bit_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [31:0]       w0_q, w1_q;
	logic signed [17:0]       x_q [USED];
	logic signed [ACC_W-1:0]  acc_q;
	logic [KW-1:0]            k_q;
	logic                     out_valid_q;
	logic signed [17:0]       audio_q;

	// Combinational datapath
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  mul_p;
	logic [31:0]               pw_sum;
	logic [32:0]               trial;
	logic                      root_ge;
	logic signed [35:0]        blend_sum;
	logic signed [31:0]        w0_sat;
	logic signed [33:0]        res;
	logic signed [17:0]        x_sat;
	logic signed [21:0]        acc_shr;
	logic signed [17:0]        audio_sat;

	assign uop      = uop_rom(step_q);
	assign s_tready = (step_q == STEP_WAIT);
	assign in_fire  = s_tvalid && s_tready;
	assign out_busy = out_valid_q && !m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, audio_q};

	// Pick the jump condition of the current step
	always_comb begin
		case (uop.jmp)
			JMP_IN_IDLE:   jump = !in_fire;
			JMP_ROOT_MORE: jump = (bit_q[31:2] != 30'd0);
			JMP_TAP_MORE:  jump = (k_q != KW'(USED - 1));
			JMP_OUT_BUSY:  jump = out_busy;
			default:       jump = 1'b0;
		endcase
	end

	// Select multiplier operands
	always_comb begin
		case (uop.mul)
			MUL_II: begin
				mul_a = MUL_A_W'(si_q);
				mul_b = MUL_B_W'(si_q);
			end
			MUL_QQ: begin
				mul_a = MUL_A_W'(sq_q);
				mul_b = MUL_B_W'(sq_q);
			end
			MUL_AW: begin
				mul_a = signed'({2'b00, alpha_q});
				mul_b = MUL_B_W'(w1_q);
			end
			MUL_TAP: begin
				mul_a = MUL_A_W'(tap_q[k_q]);
				mul_b = MUL_B_W'(x_q[k_q]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p  = mul_a * mul_b;
	assign pw_sum = pw_q + prod_q[31:0];

	// One restoring square root digit
	assign trial   = {1'b0, root_q} + {1'b0, bit_q};
	assign root_ge = ({1'b0, rem_q} >= trial);

	// Blocker feedback sum, saturated to 32 bits
	assign blend_sum = signed'({12'd0, root_q[15:0], 8'd0}) + 36'(signed'(prod_q[50:16]));
	always_comb begin
		if (blend_sum[35:31] == {5{blend_sum[35]}})
			w0_sat = blend_sum[31:0];
		else if (blend_sum[35])
			w0_sat = 32'sh8000_0000;
		else
			w0_sat = 32'sh7FFF_FFFF;
	end

	// Blocker output, dropped to integer and saturated to 18 bits
	assign res = 34'(w0_q) - 34'(w1_q);
	always_comb begin
		if (res[33:25] == {9{res[33]}})
			x_sat = res[25:8];
		else if (res[33])
			x_sat = 18'sh20000;
		else
			x_sat = 18'sh1FFFF;
	end

	// Filter output, scaled and saturated to 18 bits
	assign acc_shr = acc_q[36:15];
	always_comb begin
		if (acc_shr[21:17] == {5{acc_shr[21]}})
			audio_sat = acc_shr[17:0];
		else if (acc_shr[21])
			audio_sat = 18'sh20000;
		else
			audio_sat = 18'sh1FFFF;
	end

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RESET;
			for (int j = 0; j < REG_TAPS; j++)
				tap_q[j] <= TAP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DC_ALPHA:  alpha_q  <= cfg_data;
				REG_TAP_ZERO:  tap_q[0] <= cfg_data;
				REG_TAP_ONE:   tap_q[1] <= cfg_data;
				REG_TAP_TWO:   tap_q[2] <= cfg_data;
				REG_TAP_THREE: tap_q[3] <= cfg_data;
				REG_TAP_FOUR:  tap_q[4] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_WAIT;
		end else if (jump) begin
			step_q <= uop.target;
		end else if (uop.last) begin
			step_q <= STEP_WAIT;
		end else begin
			step_q <= step_q + 4'd1;
		end
	end

	// Hold filter state and the output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w1_q        <= '0;
			out_valid_q <= 1'b0;
			for (int j = 0; j < USED; j++)
				x_q[j] <= '0;
		end else begin
			if (uop.diff) begin
				w1_q   <= w0_q;
				x_q[0] <= x_sat;
				for (int j = 1; j < USED; j++)
					x_q[j] <= x_q[j-1];
			end
			if (uop.out_ld && !out_busy)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	// Run the datapath operations of the current step
	always_ff @(posedge clk) begin
		if (uop.load_in && in_fire) begin
			si_q <= s_tdata[15:0];
			sq_q <= s_tdata[31:16];
		end
		if (uop.mul == MUL_CLR)
			prod_q <= '0;
		else if (uop.mul != MUL_NONE)
			prod_q <= mul_p;
		if (uop.pw_load)
			pw_q <= prod_q[31:0];
		if (uop.root_init) begin
			rem_q  <= pw_sum;
			root_q <= '0;
			bit_q  <= 32'h4000_0000;
		end
		if (uop.root_step) begin
			if (root_ge) begin
				rem_q  <= rem_q - trial[31:0];
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (uop.blend)
			w0_q <= w0_sat;
		if (uop.diff) begin
			acc_q <= '0;
			k_q   <= '0;
		end
		if (uop.mac) begin
			acc_q <= acc_q + prod_q[ACC_W-1:0];
			k_q   <= k_q + KW'(1);
		end
		if (uop.sum)
			acc_q <= acc_q + prod_q[ACC_W-1:0];
		if (uop.out_ld && !out_busy)
			audio_q <= audio_sat;
	end

endmodule

// ----- bench/am_envelope_detector_tb.sv -----
`timescale 1ns / 100ps

module am_envelope_detector_tb;

	import amed_pkg::*;

	// Tracks the envelope/DC blocker/FIR chain and holds the audio words still due
	class audio_scoreboard;
		logic [15:0]        alpha;
		logic signed [15:0] taps [REG_TAPS];
		longint             blocker_acc;
		longint             history [REG_TAPS-1];
		logic [17:0]        audio_due [$];
		int                 mismatches;
		int                 checked;
		int                 noted;

		function new();
			alpha = ALPHA_RESET;
			foreach (taps[k]) taps[k] = TAP_RESET;
			blocker_acc = 0;
			foreach (history[k]) history[k] = 0;
			mismatches = 0;
			checked = 0;
			noted = 0;
		endfunction

		// Mirror one register write; spare indexes are dropped
		function void set_reg(logic [2:0] idx, logic [15:0] value);
			case (idx)
				REG_DC_ALPHA:  alpha = value;
				REG_TAP_ZERO:  taps[0] = value;
				REG_TAP_ONE:   taps[1] = value;
				REG_TAP_TWO:   taps[2] = value;
				REG_TAP_THREE: taps[3] = value;
				REG_TAP_FOUR:  taps[4] = value;
				default: ;
			endcase
		endfunction

		function longint clip(longint v, longint lo, longint hi);
			return (v < lo) ? lo : ((v > hi) ? hi : v);
		endfunction

		// Floor of the square root, two bits per pass
		function longint int_sqrt(longint x);
			longint root;
			longint b;
			root = 0;
			b = 64'h4000_0000;
			while (b > x) b = b >> 2;
			while (b != 0) begin
				if (x >= root + b) begin
					x = x - (root + b);
					root = (root >> 1) + b;
				end else begin
					root = root >> 1;
				end
				b = b >> 2;
			end
			return root;
		endfunction

		// Advance the envelope state by one accepted word and queue its audio word
		function void note_sample(logic signed [15:0] si, logic signed [15:0] sq);
			longint mag;
			longint w0;
			longint x;
			longint acc;
			mag = int_sqrt(longint'(si) * longint'(si) + longint'(sq) * longint'(sq));
			w0 = mag * 256 + ((longint'(alpha) * blocker_acc) >>> 16);
			w0 = clip(w0, -64'sd2147483648, 64'sd2147483647);
			x = clip((w0 - blocker_acc) >>> 8, -131072, 131071);
			blocker_acc = w0;
			acc = longint'(taps[0]) * x;
			for (int k = 1; k < REG_TAPS; k++)
				acc += longint'(taps[k]) * history[k-1];
			for (int k = REG_TAPS - 2; k > 0; k--)
				history[k] = history[k-1];
			history[0] = x;
			audio_due.push_back(18'(clip(acc >>> 15, -131072, 131071)));
			noted++;
		endfunction

		// Compare one accepted output word against the oldest due word
		function void check_audio(logic [17:0] got);
			logic [17:0] want;
			checked++;
			if (audio_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: audio word %h arrived with none due", $realtime, got);
				return;
			end
			want = audio_due.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: audio_sample mismatch, expected %0d got %0d", $realtime,
						$signed(want), $signed(got));
			end
		endfunction

		function int pending();
			return audio_due.size();
		endfunction
	endclass

	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	// Sample mixes for the random part
	typedef enum int {MIX_ANY, MIX_STRONG} mix_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [15:0] sample_i, [31:16] sample_q
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // [17:0] audio_sample, [23:18] zero
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	audio_scoreboard sb;
	int              send_gap_pct;
	int              recv_gap_pct;
	int              settings_used;

	am_envelope_detector uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Offer one sample word, idling first at the current rate; valid stays up after accept
	task automatic send_sample(input logic signed [15:0] si, input logic signed [15:0] sq);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {sq, si};
		do @(posedge clk); while (!s_tready);
		sb.note_sample(si, sq);
	endtask

	// Hold the input until every due audio word has come out
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Write all registers plus both spare indexes, then drop the enable
	task automatic load_config(input logic [15:0] alpha, input logic [15:0] t0,
		input logic [15:0] t1, input logic [15:0] t2, input logic [15:0] t3,
		input logic [15:0] t4);
		logic [2:0]  idx [8];
		logic [15:0] val [8];
		idx = '{REG_DC_ALPHA, REG_TAP_ZERO, REG_TAP_ONE, REG_TAP_TWO, REG_TAP_THREE,
			REG_TAP_FOUR, REG_SPARE_LO, REG_SPARE_HI};
		val = '{alpha, t0, t1, t2, t3, t4, 16'($urandom), 16'($urandom)};
		for (int k = 0; k < 8; k++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[k];
			cfg_data  <= val[k];
			@(posedge clk);
			sb.set_reg(idx[k], val[k]);
		end
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	function automatic logic [15:0] pick_tap();
		case ($urandom_range(0, 4))
			0: return 16'sd32767;
			1: return -16'sd32768;
			2: return 16'($urandom_range(0, 16383) - 8192);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_alpha();
		case ($urandom_range(0, 3))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(60000, 65535));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic signed [15:0] pick_strong();
		logic signed [15:0] v;
		v = 16'($urandom_range(20000, 32767));
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	// Random samples: mostly full range, some corners, some strong carriers; MIX_STRONG sends only strong carriers
	task automatic send_random(input int count, input mix_t mix);
		logic signed [15:0] si;
		logic signed [15:0] sq;
		int                 roll;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			if (mix == MIX_STRONG || roll < 20) begin
				si = pick_strong();
				sq = pick_strong();
			end else if (roll < 30) begin
				si = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
				sq = $urandom_range(0, 2) == 0 ? 16'sd0 : ($urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000);
			end else begin
				si = 16'($urandom);
				sq = 16'($urandom);
			end
			send_sample(si, sq);
		end
	endtask

	// Accept output words at the current stall rate
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_audio(m_tdata[17:0]);
			m_tready <= ($urandom_range(0, 99) >= recv_gap_pct);
		end
	end

	initial begin
		#20_000_000;
		$display("am_envelope_detector test failed");
		$finish;
	end

	initial begin
		logic signed [15:0] dir_i [16];
		logic signed [15:0] dir_q [16];
		sb = new();
		settings_used = 1;
		send_gap_pct = 22;
		recv_gap_pct = 57;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Corners of both fields and bit patterns at the reset settings
		dir_i = '{16'sd0, 16'sh7FFF, 16'sh8000, 16'sd0, 16'sd0, 16'sh7FFF, 16'sh8000,
			16'sh7FFF, 16'sh8000, 16'sd1, -16'sd1, 16'sd3, -16'sd3, 16'sd23170,
			16'sh5555, 16'shAAAA};
		dir_q = '{16'sd0, 16'sd0, 16'sd0, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
			16'sh8000, 16'sh7FFF, -16'sd1, 16'sd1, 16'sd4, -16'sd4, 16'sd23170,
			16'shAAAA, 16'sh5555};
		foreach (dir_i[k]) send_sample(dir_i[k], dir_q[k]);
		drain();

		// Full feedback with strong carriers: drive the blocker into saturation
		load_config(16'hFFFF, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
		send_random(300, MIX_STRONG);
		drain();

		// Drop feedback to zero: the difference clips low, the filter clips high
		load_config(16'd0, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
		send_random(150, MIX_ANY);
		drain();

		// Random settings; last one returns to the reset values
		for (int p = 0; p < 6; p++) begin
			if (p == 0) begin
				send_gap_pct = 57;
				recv_gap_pct = 22;
			end else if (p == 3) begin
				send_gap_pct = 0;
				recv_gap_pct = 0;
			end
			if (p == 5)
				load_config(ALPHA_RESET, TAP_RESET, TAP_RESET, TAP_RESET, TAP_RESET, TAP_RESET);
			else
				load_config(pick_alpha(), pick_tap(), pick_tap(), pick_tap(), pick_tap(),
					pick_tap());
			send_random(240, MIX_ANY);
			drain();
		end
		repeat (40) @(posedge clk);

		$display("Sent %0d I/Q words over %0d register settings, checked %0d audio words",
			sb.noted, settings_used, sb.checked);
		$display("Covered field corners, blocker and filter clipping, spare register writes");
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("am_envelope_detector test passed");
		end else begin
			$display("%0d mismatches, %0d audio words still due", sb.mismatches, sb.pending());
			$display("am_envelope_detector test failed");
		end
		$finish;
	end

endmodule
